@@ rtl/bmw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmw_pkg: shared types and constants of the binary morphology window unit
// Holds the operation and register codes, the structuring element bundle and
// the per-stage control bundle.
// ----------------------------------------------------------------------------
package bmw_pkg;

  localparam int unsigned ElemSize     = 7;
  localparam int unsigned MaskWidth    = ElemSize * ElemSize;
  localparam int unsigned WinSize      = 8;
  localparam int unsigned LineWidth    = WinSize - 1;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 49;

  typedef enum logic [1:0] {
    OpDilate = 2'd0,
    OpErode  = 2'd1,
    OpOpen   = 2'd2,
    OpClose  = 2'd3
  } op_mode_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegOpMode   = 3'd0,
    RegMask     = 3'd1,
    RegElemRows = 3'd2,
    RegElemCols = 3'd3,
    RegOrgRow   = 3'd4,
    RegOrgCol   = 3'd5,
    RegImgRows  = 3'd6,
    RegImgCols  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [MaskWidth-1:0] mask;
    logic [2:0]           rows;
    logic [2:0]           cols;
    logic [2:0]           orow;
    logic [2:0]           ocol;
  } elem_t;

  typedef struct packed {
    logic       dilate;
    logic [2:0] reach_r;
    logic [2:0] reach_c;
  } stage_ctl_t;

endpackage

@@ rtl/bmw_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmw_ram: simple dual-port RAM
// One write port and one read port; read data is registered and holds while
// no read is issued.
// ----------------------------------------------------------------------------
module bmw_ram #(
  parameter int unsigned Width = 7,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bmw_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmw_stage: one dilation or erosion window stage
// Keeps the last seven rows of each column in a line RAM, shifts column
// vectors into an 8x8 window and evaluates the structuring element.
// ----------------------------------------------------------------------------
module bmw_stage #(
  parameter int unsigned MaxWidth  = 1024,
  parameter int unsigned MaxHeight = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  bmw_pkg::stage_ctl_t              ctl_i,
  input  bmw_pkg::elem_t                   elem_i,
  input  logic [$clog2(MaxHeight+1)-1:0]   img_rows_i,
  input  logic [$clog2(MaxWidth+1)-1:0]    img_cols_i,
  input  logic                             in_valid_i,
  input  logic                             in_pixel_i,
  input  logic                             in_first_i,
  output logic                             out_valid_o,
  output logic                             out_pixel_o,
  output logic                             out_first_o,
  output logic                             out_last_o
);

  import bmw_pkg::*;

  localparam int unsigned XW = $clog2(MaxWidth);
  localparam int unsigned WW = $clog2(MaxWidth + 1);
  localparam int unsigned HW = $clog2(MaxHeight + 1);
  localparam int unsigned YW = $clog2(MaxHeight + 16);
  localparam int unsigned NW = $clog2((MaxHeight + 16) * MaxWidth);

  // input position
  logic [XW-1:0] x_q, x_cur;
  logic [NW-1:0] n_q, n_cur;
  logic          take;

  // read stage
  logic                 v1_q, pix1_q, first1_q;
  logic [XW-1:0]        x1_q;
  logic [NW-1:0]        n1_q;
  logic [LineWidth-1:0] rdata, line1, wdata1;
  logic [WinSize-1:0]   col1;
  logic                 fwd_hit_q;
  logic [LineWidth-1:0] fwd_data_q;

  // window stage
  logic                             v2_q, first2_q;
  logic [NW-1:0]                    n2_q;
  logic [WinSize-1:0][WinSize-1:0]  win_q;

  // output position and evaluation
  logic [YW-1:0]      oy_q, oy_cur;
  logic [XW-1:0]      ox_q, ox_cur;
  logic [NW-1:0]      lag;
  logic               emit, res, last;
  logic [WinSize-1:0] rv, cv;

  // output stage
  logic v3_q, pix3_q, first3_q, last3_q;

  // count input positions, restart on the first beat of a frame
  assign take  = adv_i && in_valid_i;
  assign x_cur = in_first_i ? '0 : x_q;
  assign n_cur = in_first_i ? '0 : n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      n_q <= '0;
    end else if (take) begin
      x_q <= (WW'(x_cur) + WW'(1) == img_cols_i) ? '0 : x_cur + XW'(1);
      n_q <= n_cur + NW'(1);
    end
  end

  bmw_ram #(
    .Width (LineWidth),
    .Depth (MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (adv_i && v1_q),
    .waddr_i (x1_q),
    .wdata_i (wdata1),
    .re_i    (take),
    .raddr_i (x_cur),
    .rdata_o (rdata)
  );

  // read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else if (adv_i) begin
      v1_q      <= take;
      fwd_hit_q <= take && v1_q && (x_cur == x1_q);
    end
  end

  // read stage payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      fwd_data_q <= wdata1;
    end
    if (take) begin
      pix1_q   <= in_pixel_i;
      first1_q <= in_first_i;
      x1_q     <= x_cur;
      n1_q     <= n_cur;
    end
  end

  // forward the column word written in the same cycle as its read
  assign line1  = fwd_hit_q ? fwd_data_q : rdata;
  assign col1   = {line1, pix1_q};
  assign wdata1 = {line1[LineWidth-2:0], pix1_q};

  // window stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v2_q <= v1_q;
    end
  end

  // shift the new column into the window
  always_ff @(posedge clk_i) begin
    if (adv_i && v1_q) begin
      win_q    <= {win_q[WinSize-2:0], col1};
      first2_q <= first1_q;
      n2_q     <= n1_q;
    end
  end

  // output position and lag of this stage
  assign lag    = NW'(ctl_i.reach_r) * NW'(img_cols_i) + NW'(ctl_i.reach_c);
  assign emit   = n2_q >= lag;
  assign oy_cur = first2_q ? '0 : oy_q;
  assign ox_cur = first2_q ? '0 : ox_q;
  assign last   = (oy_cur == YW'(img_rows_i - HW'(1))) &&
                  (WW'(ox_cur) == img_cols_i - WW'(1));

  // mark window rows and columns that fall inside the image
  always_comb begin
    logic signed [YW+1:0] ty;
    logic signed [XW+1:0] tx;
    for (int i = 0; i < WinSize; i++) begin
      ty    = $signed({2'b00, oy_cur}) + $signed((YW+2)'(ctl_i.reach_r))
              - $signed((YW+2)'(i));
      tx    = $signed({2'b00, ox_cur}) + $signed((XW+2)'(ctl_i.reach_c))
              - $signed((XW+2)'(i));
      rv[i] = (ty >= 0) && (ty < $signed((YW+2)'(img_rows_i)));
      cv[i] = (tx >= 0) && (tx < $signed((XW+2)'(img_cols_i)));
    end
  end

  // evaluate the structuring element over the window
  always_comb begin
    logic       acc;
    logic [3:0] rp, cp;
    rp = '0;
    cp = '0;
    if (ctl_i.dilate) begin
      acc = 1'b0;
      for (int r = 0; r < ElemSize; r++) begin
        for (int c = 0; c < ElemSize; c++) begin
          if ((r < int'(elem_i.rows)) && (c < int'(elem_i.cols)) &&
              elem_i.mask[r*ElemSize+c] && win_q[c][r] && rv[r] && cv[c]) begin
            acc = 1'b1;
          end
        end
      end
    end else begin
      acc = win_q[ctl_i.reach_c][ctl_i.reach_r] && rv[ctl_i.reach_r] &&
            cv[ctl_i.reach_c];
      for (int r = 0; r < ElemSize; r++) begin
        for (int c = 0; c < ElemSize; c++) begin
          rp = 4'(ctl_i.reach_r) + 4'(elem_i.orow) - 4'(r);
          cp = 4'(ctl_i.reach_c) + 4'(elem_i.ocol) - 4'(c);
          if ((r < int'(elem_i.rows)) && (c < int'(elem_i.cols)) &&
              elem_i.mask[r*ElemSize+c] &&
              !(win_q[cp[2:0]][rp[2:0]] && rv[rp[2:0]] && cv[cp[2:0]])) begin
            acc = 1'b0;
          end
        end
      end
    end
    res = acc && (oy_cur < YW'(img_rows_i));
  end

  // advance the output position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oy_q <= '0;
      ox_q <= '0;
    end else if (adv_i && v2_q) begin
      if (emit) begin
        if (WW'(ox_cur) + WW'(1) == img_cols_i) begin
          ox_q <= '0;
          oy_q <= oy_cur + YW'(1);
        end else begin
          ox_q <= ox_cur + XW'(1);
          oy_q <= oy_cur;
        end
      end else begin
        ox_q <= ox_cur;
        oy_q <= oy_cur;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v3_q <= v2_q && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && v2_q) begin
      pix3_q   <= res;
      first3_q <= (n2_q == lag);
      last3_q  <= last;
    end
  end

  assign out_valid_o = v3_q;
  assign out_pixel_o = pix3_q;
  assign out_first_o = first3_q;
  assign out_last_o  = last3_q;

`ifndef SYNTHESIS
  // a forwarded line word always belongs to a read beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> v1_q)
    else $error("line forwarding without a read beat");

  // a result appears only from a valid window beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v3_q) |-> $past(v2_q))
    else $error("result without window beat");

  // the beat at the lag opens the output frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && v2_q && (n2_q == lag)) |=> (v3_q && first3_q))
    else $error("first result of frame not marked");
`endif

endmodule

@@ rtl/binary_morphology_window_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_morphology_window_unit: streaming binary dilation, erosion,
// opening and closing with a configurable element of up to 7x7
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one pixel in raster order; a frame is rows*cols pixel
//   beats followed by lag flush beats, lag = R*cols + C summed over the stages
//   in use (dilation reaches origin rows/cols, erosion the element size minus
//   one minus the origin, never below zero).
//   Output beats give the result image in raster order; last_pixel marks the
//   final pixel of the frame.
//   Throughput is one beat per cycle while the receiver accepts. Each window
//   stage is pipelined through the line RAM read, the window shift and the
//   result register. The line RAM read sets the stage depth; a same-column
//   write and read are forwarded.
//   Reset clears the frame count and the pipeline; line RAM contents stay
//   undefined and are masked until rewritten. A configuration write restarts
//   the frame count. While the receiver stalls the whole pipeline holds and
//   in_ready_o drops.
// ----------------------------------------------------------------------------
module binary_morphology_window_unit #(
  parameter int unsigned MaxWidth  = 1024,
  parameter int unsigned MaxHeight = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bmw_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [bmw_pkg::CfgDataWidth-1:0]    cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                in_pixel_i,
  input  logic                                in_flush_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                out_pixel_o,
  output logic                                out_last_pixel_o
);

  import bmw_pkg::*;

  localparam int unsigned WW = $clog2(MaxWidth + 1);
  localparam int unsigned HW = $clog2(MaxHeight + 1);
  localparam int unsigned NW = $clog2((MaxHeight + 16) * MaxWidth);

  op_mode_e             op_q;
  logic [MaskWidth-1:0] mask_q;
  logic [2:0]           erows_q, ecols_q, orow_q, ocol_q;
  logic [10:0]          irows_q, icols_q;

  logic [HW-1:0] h_eff;
  logic [WW-1:0] w_eff;
  elem_t         elem;
  stage_ctl_t    ctl1, ctl2;
  logic [2:0]    ero_r, ero_c;
  logic          dual;
  logic [NW-1:0] total, frame_lag, frame_last, pos_q;
  logic          adv, take, first, pix_in;

  logic s1_valid, s1_pixel, s1_first, s1_last;
  logic s2_valid, s2_pixel, s2_first, s2_last;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_reset: begin
        op_q    <= OpDilate;
        mask_q  <= '0;
        erows_q <= 3'd3;
        ecols_q <= 3'd3;
        orow_q  <= 3'd1;
        ocol_q  <= 3'd1;
        irows_q <= 11'd1024;
        icols_q <= 11'd1024;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegOpMode:   op_q    <= op_mode_e'(cfg_data_i[1:0]);
        RegMask:     mask_q  <= cfg_data_i[MaskWidth-1:0];
        RegElemRows: erows_q <= cfg_data_i[2:0];
        RegElemCols: ecols_q <= cfg_data_i[2:0];
        RegOrgRow:   orow_q  <= cfg_data_i[2:0];
        RegOrgCol:   ocol_q  <= cfg_data_i[2:0];
        RegImgRows:  irows_q <= cfg_data_i[10:0];
        RegImgCols:  icols_q <= cfg_data_i[10:0];
        default:     op_q    <= op_q;
      endcase
    end
  end

  // clamp the frame size
  always_comb begin
    if (irows_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(irows_q) > MaxHeight) begin
      h_eff = HW'(MaxHeight);
    end else begin
      h_eff = HW'(irows_q);
    end
    if (icols_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(icols_q) > MaxWidth) begin
      w_eff = WW'(MaxWidth);
    end else begin
      w_eff = WW'(icols_q);
    end
  end

  // stage reaches
  always_comb begin
    logic signed [4:0] dr, dc;
    dr    = $signed({2'b00, erows_q}) - 5'sd1 - $signed({2'b00, orow_q});
    dc    = $signed({2'b00, ecols_q}) - 5'sd1 - $signed({2'b00, ocol_q});
    ero_r = (dr < 0) ? 3'd0 : dr[2:0];
    ero_c = (dc < 0) ? 3'd0 : dc[2:0];
  end

  assign elem = '{mask: mask_q, rows: erows_q, cols: ecols_q,
                  orow: orow_q, ocol: ocol_q};
  assign dual = (op_q == OpOpen) || (op_q == OpClose);

  assign ctl1.dilate  = (op_q == OpDilate) || (op_q == OpClose);
  assign ctl1.reach_r = ctl1.dilate ? orow_q : ero_r;
  assign ctl1.reach_c = ctl1.dilate ? ocol_q : ero_c;
  assign ctl2.dilate  = (op_q == OpOpen);
  assign ctl2.reach_r = ctl2.dilate ? orow_q : ero_r;
  assign ctl2.reach_c = ctl2.dilate ? ocol_q : ero_c;

  // frame length in beats
  assign total      = NW'(h_eff) * NW'(w_eff);
  assign frame_lag  = (NW'(ctl1.reach_r) + (dual ? NW'(ctl2.reach_r) : '0)) * NW'(w_eff)
                      + NW'(ctl1.reach_c) + (dual ? NW'(ctl2.reach_c) : '0);
  assign frame_last = total + frame_lag - NW'(1);

  // global advance: the pipeline moves when the output slot is free or its beat is accepted
  assign out_valid_o = dual ? s2_valid : s1_valid;
  assign adv         = !out_valid_o || out_ready_i;
  assign in_ready_o  = adv;
  assign take        = in_valid_i && adv;

  // frame beat counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (cfg_we_i) begin
      pos_q <= '0;
    end else if (take) begin
      pos_q <= (pos_q >= frame_last) ? '0 : pos_q + NW'(1);
    end
  end

  // drop flush beats and beats past the image to background
  assign first  = (pos_q == '0);
  assign pix_in = in_pixel_i && !in_flush_i && (pos_q < total);

  bmw_stage #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_stage1 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .ctl_i       (ctl1),
    .elem_i      (elem),
    .img_rows_i  (h_eff),
    .img_cols_i  (w_eff),
    .in_valid_i  (in_valid_i),
    .in_pixel_i  (pix_in),
    .in_first_i  (first),
    .out_valid_o (s1_valid),
    .out_pixel_o (s1_pixel),
    .out_first_o (s1_first),
    .out_last_o  (s1_last)
  );

  bmw_stage #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_stage2 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .ctl_i       (ctl2),
    .elem_i      (elem),
    .img_rows_i  (h_eff),
    .img_cols_i  (w_eff),
    .in_valid_i  (s1_valid),
    .in_pixel_i  (s1_pixel),
    .in_first_i  (s1_first),
    .out_valid_o (s2_valid),
    .out_pixel_o (s2_pixel),
    .out_first_o (s2_first),
    .out_last_o  (s2_last)
  );

  // select the result of the last stage in use
  assign out_pixel_o      = dual ? s2_pixel : s1_pixel;
  assign out_last_pixel_o = dual ? (s2_last && !s2_first) || (s2_last && s2_first)
                                 : s1_last;

endmodule
